@@ rtl/core/trps_pkg.sv @@
package trps_pkg;

  localparam int PIX_W         = 24;
  localparam int MAX_RUN_DEF   = 63;
  localparam int CFG_IDX_W     = 1;

  localparam logic [PIX_W-1:0] THRESHOLD_RST = 24'd10010000;
  localparam logic [PIX_W-1:0] REFERENCE_RST = 24'hFFFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the incoming pixel request
    logic insert;        // insert the captured pixel into the sorted run
    logic pop;           // move the smallest held pixel to the output register
    logic pop_row_end;   // popped pixel closes the row if it is the last one held
    logic pop_burst_end; // popped pixel ends the burst if it is the last one held
    logic emit_light;    // move the captured light pixel to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dark;
    logic row_end;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full_next;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/threshold_run_pixel_sorter.sv @@
// Channel | Direction | Handshake          | Contents
// s_*     | in        | s_tvalid, s_tready | s_tdata = pixel_in[23:0], s_tlast = row_end
// m_*     | out       | m_tvalid, m_tready | m_tdata = pixel_out[23:0], m_tlast = row_end_out,
//         |           |                    | m_tuser = burst_end
// cfg_*   | in        | cfg_we             | cfg_index (0 threshold, 1 reference_color), cfg_data
//
// A dark pixel that stays held is captured from the request, then classified and inserted
// into the sorted run of slots in a single step. A flush sends one held pixel per cycle
// while the output is free; a light pixel after a run goes out once the whole run has been
// sent, and a dark pixel that closes a run is inserted first and then flushed with it.
// Reset is synchronous; it empties the run and restores both registers. A stalled output
// holds the sequencer in place; no request is taken until a burst's last pixel is loaded.
module threshold_run_pixel_sorter #(
  parameter int MaxRun = trps_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [trps_pkg::PIX_W-1:0]     s_tdata,   // [23:0] pixel_in
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [trps_pkg::PIX_W-1:0]     m_tdata,   // [23:0] pixel_out
  output logic                           m_tlast,
  output logic                           m_tuser,   // [0] burst_end
  input  logic                           cfg_we,
  input  logic [trps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trps_pkg::PIX_W-1:0]     cfg_data
);
  import trps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  trps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  trps_dp #(
    .MaxRun (MaxRun)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .pixel_in      (s_tdata),
    .row_end_in    (s_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_pixel     (m_tdata),
    .out_row_end   (m_tlast),
    .out_burst_end (m_tuser)
  );

endmodule

@@ rtl/core/trps_dp.sv @@
module trps_dp #(
  parameter int MaxRun = trps_pkg::MAX_RUN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  trps_pkg::dp_cmd_t              cmd,
  output trps_pkg::dp_status_t           status,
  input  logic [trps_pkg::PIX_W-1:0]     pixel_in,
  input  logic                           row_end_in,
  input  logic                           cfg_we,
  input  logic [trps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trps_pkg::PIX_W-1:0]     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [trps_pkg::PIX_W-1:0]     out_pixel,
  output logic                           out_row_end,
  output logic                           out_burst_end
);
  import trps_pkg::*;

  localparam int CntW = $clog2(MaxRun + 1);

  logic [PIX_W-1:0] threshold;
  logic [PIX_W-1:0] reference_color;
  logic [PIX_W-1:0] pix;
  logic             row_end;
  logic [CntW-1:0]  count;
  logic [PIX_W-1:0] slot [MaxRun];
  logic [MaxRun-1:0] gt;
  logic [PIX_W:0]   diff;
  logic             load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= THRESHOLD_RST;
      reference_color <= REFERENCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold       <= cfg_data;
        CFG_REFERENCE: reference_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix     <= pixel_in;
      row_end <= row_end_in;
    end
  end

  // A pixel is dark only when it is below the reference by more than the threshold.
  assign diff = {1'b0, reference_color} - {1'b0, pix};

  // Insertion chain: every slot sees the new pixel and its lower neighbor. Slots at or
  // beyond the fill count act as larger than any pixel, so the new pixel lands at the
  // first slot that holds something larger and everything above moves up one place.
  for (genvar i = 0; i < MaxRun; i++) begin : g_slot
    assign gt[i] = (slot[i] > pix) || (CntW'(i) >= count);

    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.insert && gt[i]) begin
          slot[i] <= pix;
        end else if (cmd.pop) begin
          slot[i] <= slot[i+1];
        end
      end
    end else if (i == MaxRun - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.insert && gt[i]) begin
          slot[i] <= gt[i-1] ? slot[i-1] : pix;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.insert && gt[i]) begin
          slot[i] <= gt[i-1] ? slot[i-1] : pix;
        end else if (cmd.pop) begin
          slot[i] <= slot[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CntW'(1);
    end else if (cmd.pop) begin
      count <= count - CntW'(1);
    end
  end

  assign load_out = cmd.pop || cmd.emit_light;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_pixel     <= slot[0];
      out_row_end   <= cmd.pop_row_end && status.cnt_one;
      out_burst_end <= cmd.pop_burst_end && status.cnt_one;
    end else if (cmd.emit_light) begin
      out_pixel     <= pix;
      out_row_end   <= row_end;
      out_burst_end <= 1'b1;
    end
  end

  assign status.dark          = !diff[PIX_W] && (diff[PIX_W-1:0] > threshold);
  assign status.row_end       = row_end;
  assign status.cnt_zero      = (count == '0);
  assign status.cnt_one       = (count == CntW'(1));
  assign status.cnt_full_next = (count == CntW'(MaxRun - 1));
  assign status.out_free      = !out_valid || out_ready;

endmodule

@@ rtl/core/trps_ctrl.sv @@
module trps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  trps_pkg::dp_status_t status,
  output trps_pkg::dp_cmd_t    cmd
);
  import trps_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WORK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_LIGHT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       light;
  logic       light_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      light <= 1'b0;
    end else begin
      state <= state_next;
      light <= light_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    light_next = light;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_WORK;
        end
      end
      S_WORK: begin
        light_next = !status.dark;
        if (status.dark) begin
          cmd.insert = 1'b1;
          if (status.row_end || status.cnt_full_next) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_IDLE;
          end
        end else if (status.cnt_zero) begin
          state_next = S_LIGHT;
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // A run flushed ahead of a light pixel never closes the row or the burst.
        if (status.out_free) begin
          cmd.pop           = 1'b1;
          cmd.pop_row_end   = !light && status.row_end;
          cmd.pop_burst_end = !light;
          if (status.cnt_one) begin
            state_next = light ? S_LIGHT : S_IDLE;
          end
        end
      end
      S_LIGHT: begin
        if (status.out_free) begin
          cmd.emit_light = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/trps_checker.sv @@
module trps_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [trps_pkg::PIX_W-1:0] m_tdata,
  input logic                       m_tlast,
  input logic                       m_tuser
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // The block works on one request at a time, so it cannot take one in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one is in work");

  // The pixel that ends a row is always the last result of its request.
  a_row_end_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("row end without burst end");

endmodule

bind threshold_run_pixel_sorter trps_checker u_trps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

@@ tb/sv/threshold_run_pixel_sorter_tb.sv @@
module threshold_run_pixel_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trps_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [PIX_W-1:0] PIX_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             burst_end;
  } sorted_pixel_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [PIX_W-1:0]     s_tdata = '0;     // [23:0] pixel_in
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [PIX_W-1:0]     m_tdata;          // [23:0] pixel_out
  logic                 m_tlast;
  logic                 m_tuser;          // [0] burst_end
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PIX_W-1:0]     cfg_data = '0;

  // Sorter shadow state and the pixels it says must come out, oldest first.
  logic [PIX_W-1:0] thr_q;
  logic [PIX_W-1:0] ref_q;
  logic [PIX_W-1:0] held_run[$];
  sorted_pixel_t    pending_pixels[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;
  int  hold_request = 0;

  threshold_run_pixel_sorter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit pixel_is_dark(logic [PIX_W-1:0] px);
    return (ref_q > px) && ((ref_q - px) > thr_q);
  endfunction

  function automatic void flush_held_run(bit last_of_row);
    sorted_pixel_t r;
    for (int k = 0; k < held_run.size(); k++) begin
      r.pixel     = held_run[k];
      r.row_end   = last_of_row && (k == held_run.size() - 1);
      r.burst_end = 1'b0;
      pending_pixels.push_back(r);
    end
    held_run.delete();
  endfunction

  function automatic void sort_pixel(logic [PIX_W-1:0] px, bit last);
    int            before_cnt;
    int            pos;
    sorted_pixel_t r;
    before_cnt = pending_pixels.size();
    if (pixel_is_dark(px)) begin
      pos = 0;
      while (pos < held_run.size() && held_run[pos] <= px) pos++;
      held_run.insert(pos, px);
      if (last || held_run.size() >= MAX_RUN_DEF) flush_held_run(last);
    end else begin
      flush_held_run(1'b0);
      r.pixel     = px;
      r.row_end   = last;
      r.burst_end = 1'b0;
      pending_pixels.push_back(r);
    end
    if (pending_pixels.size() > before_cnt) begin
      r = pending_pixels.pop_back();
      r.burst_end = 1'b1;
      pending_pixels.push_back(r);
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_dark();
    logic [PIX_W-1:0] top;
    if (ref_q <= thr_q) return PIX_W'($urandom);
    top = ref_q - thr_q - PIX_W'(1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return top;
      default: return PIX_W'($urandom_range(0, top));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_light();
    logic [PIX_W-1:0] low;
    low = (ref_q > thr_q) ? ref_q - thr_q : '0;
    case ($urandom_range(0, 7))
      0: return low;
      1: return PIX_MAX;
      default: return PIX_W'($urandom_range(low, PIX_MAX));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
    end else begin
      gap = 0;
    end
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sort_pixel(px, last);
    burst_left--;
  endtask

  // Registers may only change once the last burst is out and the final
  // pixel has had time to settle into the run.
  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_THRESHOLD: thr_q = value;
      CFG_REFERENCE: ref_q = value;
      default: ;
    endcase
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic send_random_rows(input int count);
    int               sent;
    int               row_len;
    int               seg_left;
    bit               seg_dark;
    bit               last;
    logic [PIX_W-1:0] px;
    sent = 0;
    seg_left = 0;
    seg_dark = 1'b0;
    while (sent < count) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
      for (int i = 0; i < row_len && sent < count; i++) begin
        if (seg_left == 0) begin
          seg_dark = !seg_dark;
          if (!seg_dark) seg_left = $urandom_range(1, 3);
          else if ($urandom_range(0, 14) == 0) seg_left = $urandom_range(55, 70);
          else seg_left = $urandom_range(1, 10);
        end
        seg_left--;
        if ($urandom_range(0, 11) == 0) px = PIX_W'($urandom);
        else px = seg_dark ? pick_dark() : pick_light();
        last = (i == row_len - 1) || ($urandom_range(0, 29) == 0);
        send_pixel(px, last);
        sent++;
      end
    end
  endtask

  task automatic test_directed_cases();
    logic [PIX_W-1:0] border_px;
    // At the border the difference equals the threshold, which is still light.
    border_px = ref_q - thr_q;
    send_pixel(PIX_MAX, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(border_px - PIX_W'(1), 1'b0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(border_px, 1'b0);
    send_pixel(24'h000010, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h000005, 1'b0);
    send_pixel(24'h000005, 1'b0);
    send_pixel(24'h000003, 1'b1);
    send_pixel(24'h800000, 1'b1);
    send_pixel(24'h000003, 1'b0);
    send_pixel(24'hABCDEF, 1'b1);
    // The held run must survive a register change and flush under the new values.
    send_pixel(24'h654321, 1'b0);
    send_pixel(24'h000100, 1'b0);
    set_register(CFG_REFERENCE, 24'h000200);
    set_register(CFG_THRESHOLD, 24'h000010);
    send_pixel(24'h000300, 1'b0);
    send_pixel(24'h000100, 1'b0);
    send_pixel(24'h0001F8, 1'b1);
    set_register(CFG_THRESHOLD, THRESHOLD_RST);
    set_register(CFG_REFERENCE, REFERENCE_RST);
  endtask

  task automatic test_run_split();
    set_register(CFG_THRESHOLD, 24'h000000);
    set_register(CFG_REFERENCE, PIX_MAX);
    for (int i = 0; i < MAX_RUN_DEF; i++) send_pixel(pick_dark(), 1'b0);
    for (int i = 0; i < MAX_RUN_DEF; i++) send_pixel(pick_dark(), i == MAX_RUN_DEF - 1);
    // Descending start so the insertion has to move every held pixel.
    for (int i = 0; i < MAX_RUN_DEF + 2; i++) begin
      send_pixel((i < 20) ? 24'(100 - i) : pick_dark(), 1'b0);
    end
    send_pixel(PIX_MAX, 1'b1);
  endtask

  task automatic test_backpressure();
    set_register(CFG_THRESHOLD, THRESHOLD_RST);
    sender_gaps = 1'b0;
    hold_request = 400;
    send_random_rows(50);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    send_random_rows(30);
    set_register(CFG_THRESHOLD, 24'h000000);
    send_random_rows(15);
    set_register(CFG_THRESHOLD, PIX_MAX);
    send_random_rows(10);
    set_register(CFG_THRESHOLD, PIX_W'($urandom_range(0, 24'h3FFFFF)));
    set_register(CFG_REFERENCE, 24'h000000);
    send_random_rows(10);
    set_register(CFG_THRESHOLD, PIX_W'($urandom_range(0, 24'h7FFFFF)));
    set_register(CFG_REFERENCE, PIX_W'($urandom_range(24'h400000, PIX_MAX)));
    send_random_rows(25);
  endtask

  initial begin
    thr_q = THRESHOLD_RST;
    ref_q = REFERENCE_RST;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed_cases();
    test_run_split();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Output side: stalls follow a mode that changes now and then, and a long
  // hold-off can be requested to back the block up.
  always @(negedge clk) begin : drive_ready
    static rx_mode_t rx_mode = RX_ALWAYS;
    static int mode_left = 0;
    static int hold_left = 0;
    static int phase = 0;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      case (rx_mode)
        RX_ALWAYS:  m_tready <= 1'b1;
        RX_RANDOM:  m_tready <= ($urandom_range(0, 9) < 7);
        RX_PATTERN: m_tready <= ((phase % 5) < 3);
        default:    m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_pixels
    sorted_pixel_t want;
    sorted_pixel_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.pixel     = m_tdata;
      got.row_end   = m_tlast;
      got.burst_end = m_tuser;
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected pixel %h row_end %b burst_end %b", $realtime,
                   got.pixel, got.row_end, got.burst_end);
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
            got.burst_end !== want.burst_end) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: pixel %h/%h row_end %b/%b burst_end %b/%b (expected/actual)",
                     $realtime, want.pixel, got.pixel, want.row_end, got.row_end,
                     want.burst_end, got.burst_end);
        end
      end
    end
  end

endmodule
